// File: src/fcrc8_pkg.sv
`timescale 1ns / 1ps

package fcrc8_pkg;

  // Field widths of the channels.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned EventW    = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegPrefix = 3'd0;
  localparam logic [CfgIndexW-1:0] RegPoly   = 3'd1;
  localparam logic [CfgIndexW-1:0] RegCmd0   = 3'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] PrefixReset = 16'h236B;
  localparam logic [7:0]  PolyReset   = 8'h18;

  // Shortest packet: two prefix bytes, the command byte and the CRC byte.
  localparam logic [7:0] MinLen = 8'd4;
  // Bytes of a packet already consumed when the command is accepted.
  localparam logic [7:0] HeadLen = 8'd3;

  // Event codes reported for each received byte.
  typedef enum logic [EventW-1:0] {
    EV_DISCARD = 3'd0,
    EV_PREFIX  = 3'd1,
    EV_CMD_OK  = 3'd2,
    EV_BODY    = 3'd3,
    EV_GOOD    = 3'd4,
    EV_CRC_BAD = 3'd5,
    EV_UNKNOWN = 3'd6
  } event_e;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LOW  = 2'd1,
    PH_CMD  = 2'd2,
    PH_REST = 2'd3
  } phase_e;

  // One byte of the reflected CRC-8, least significant bit first.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data,
                                           logic [7:0] poly);
    logic [7:0] crc;
    logic [7:0] b;
    crc = crc_in;
    b   = data;
    for (int k = 0; k < 8; k++) begin
      if ((b[0] ^ crc[0]) == 1'b1) begin
        crc = ((crc ^ poly) >> 1) | 8'h80;
      end else begin
        crc = crc >> 1;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

// File: src/fcrc8_if.sv
`timescale 1ns / 1ps

// Received byte channel.
interface fcrc8_rx_if import fcrc8_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Event channel, one transaction per received byte.
interface fcrc8_evt_if import fcrc8_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic [ByteW-1:0]  data_byte;
  logic [ByteW-1:0]  position;
  logic [ByteW-1:0]  command_code;

  modport source (output valid, output event_res, output data_byte, output position,
                  output command_code, input ready);
  modport sink   (input valid, input event_res, input data_byte, input position,
                  input command_code, output ready);
endinterface

// Configuration write channel.
interface fcrc8_cfg_if import fcrc8_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/framed_command_receiver_crc8_top.sv
// The event for a byte is loaded into the output register when the byte is accepted.
// Throughput: one byte per cycle unless the event output stalls; the parser, table
// compare and the unrolled CRC step all sit between the parser state and the output register.
// A byte is accepted whenever the output register is empty or is being drained.
// Reset (rst_ni low, asynchronous) returns the parser to prefix hunting, clears the
// output register and loads the reset values of all configuration registers.
`timescale 1ns / 1ps

module framed_command_receiver_crc8_top import fcrc8_pkg::*; #(
  parameter int unsigned CMD_ENTRIES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  fcrc8_rx_if.sink    rx_i,
  fcrc8_evt_if.source evt_o,
  fcrc8_cfg_if.sink   cfg_i
);

  localparam int unsigned EntryIdxW = (CMD_ENTRIES > 1) ? $clog2(CMD_ENTRIES) : 1;

  // Configuration registers.
  logic [15:0] prefix_q;
  logic [7:0]  poly_q;
  logic [15:0] cmd_entry_q [CMD_ENTRIES];

  // Parser state.
  phase_e     phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] cur_cmd_q, cur_cmd_d;
  logic [7:0] byte_idx_q, byte_idx_d;

  // Output register.
  logic       out_valid_q;
  event_e     ev_q, ev_d;
  logic [7:0] data_q;
  logic [7:0] pos_q, pos_d;
  logic [7:0] cmd_q, cmd_d;

  logic       rx_acc;
  logic [7:0] d;
  logic       hi_match, lo_match;
  logic       crc_restart;
  logic [7:0] crc_new;
  logic       found;
  logic [7:0] len_found;
  logic [7:0] len_eff;
  logic       last_byte;
  logic [CfgIndexW-1:0] cfg_off;

  assign rx_i.ready   = !out_valid_q || evt_o.ready;
  assign rx_acc       = rx_i.valid && rx_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign d            = rx_i.rx_byte;

  assign evt_o.valid        = out_valid_q;
  assign evt_o.event_res    = ev_q;
  assign evt_o.data_byte    = data_q;
  assign evt_o.position     = pos_q;
  assign evt_o.command_code = cmd_q;

  // Configuration writes; an index beyond the table is ignored.
  assign cfg_off = cfg_i.index - RegCmd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= PrefixReset;
      poly_q   <= PolyReset;
      for (int i = 0; i < CMD_ENTRIES; i++) begin
        cmd_entry_q[i] <= '0;
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == RegPrefix) begin
        prefix_q <= cfg_i.data;
      end else if (cfg_i.index == RegPoly) begin
        poly_q <= cfg_i.data[7:0];
      end else if (cfg_i.index >= RegCmd0 && cfg_off < CfgIndexW'(CMD_ENTRIES)) begin
        cmd_entry_q[cfg_off[EntryIdxW-1:0]] <= cfg_i.data;
      end
    end
  end

  // Prefix compares.
  assign hi_match = (d == prefix_q[15:8]);
  assign lo_match = (d == prefix_q[7:0]);

  // One CRC unit; it starts from zero whenever a new prefix begins.
  assign crc_restart = (phase_q == PH_HUNT) || (phase_q == PH_LOW && !lo_match);
  assign crc_new     = crc8_byte(crc_restart ? 8'h00 : crc_q, d, poly_q);

  // Command table search: first match wins, a zero code ends the table.
  always_comb begin
    logic stop;
    stop      = 1'b0;
    found     = 1'b0;
    len_found = '0;
    for (int i = 0; i < CMD_ENTRIES; i++) begin
      if (!stop) begin
        if (cmd_entry_q[i][15:8] == 8'h00) begin
          stop = 1'b1;
        end else if (cmd_entry_q[i][15:8] == d) begin
          stop      = 1'b1;
          found     = 1'b1;
          len_found = cmd_entry_q[i][7:0];
        end
      end
    end
  end

  assign len_eff   = (len_found < MinLen) ? MinLen : len_found;
  assign last_byte = (bytes_left_q <= 8'd1);

  // Next parser state.
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    crc_d        = crc_q;
    cur_cmd_d    = cur_cmd_q;
    byte_idx_d   = byte_idx_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (hi_match) begin
          phase_d    = PH_LOW;
          crc_d      = crc_new;
          byte_idx_d = 8'd1;
        end
      end
      PH_LOW: begin
        if (lo_match) begin
          phase_d    = PH_CMD;
          crc_d      = crc_new;
          byte_idx_d = byte_idx_q + 8'd1;
        end else if (hi_match) begin
          crc_d      = crc_new;
          byte_idx_d = 8'd1;
        end else begin
          phase_d      = PH_HUNT;
          bytes_left_d = '0;
        end
      end
      PH_CMD: begin
        if (found) begin
          phase_d      = PH_REST;
          bytes_left_d = len_eff - HeadLen;
          cur_cmd_d    = d;
          crc_d        = crc_new;
          byte_idx_d   = byte_idx_q + 8'd1;
        end else begin
          phase_d      = PH_HUNT;
          bytes_left_d = '0;
        end
      end
      PH_REST: begin
        if (last_byte) begin
          phase_d      = PH_HUNT;
          bytes_left_d = '0;
        end else begin
          crc_d        = crc_new;
          bytes_left_d = bytes_left_q - 8'd1;
          byte_idx_d   = byte_idx_q + 8'd1;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // Event for the current byte.
  always_comb begin
    ev_d  = EV_DISCARD;
    pos_d = '0;
    cmd_d = '0;
    unique case (phase_q)
      PH_HUNT: begin
        ev_d = hi_match ? EV_PREFIX : EV_DISCARD;
      end
      PH_LOW: begin
        if (lo_match) begin
          ev_d  = EV_PREFIX;
          pos_d = byte_idx_q;
        end else if (hi_match) begin
          ev_d = EV_PREFIX;
        end
      end
      PH_CMD: begin
        ev_d  = found ? EV_CMD_OK : EV_UNKNOWN;
        pos_d = byte_idx_q;
        cmd_d = d;
      end
      PH_REST: begin
        if (last_byte) begin
          ev_d = (d == crc_q) ? EV_GOOD : EV_CRC_BAD;
        end else begin
          ev_d = EV_BODY;
        end
        pos_d = byte_idx_q;
        cmd_d = cur_cmd_q;
      end
      default: begin
        ev_d = EV_DISCARD;
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      bytes_left_q <= '0;
      crc_q        <= '0;
      cur_cmd_q    <= '0;
      byte_idx_q   <= '0;
    end else if (rx_acc) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      crc_q        <= crc_d;
      cur_cmd_q    <= cur_cmd_d;
      byte_idx_q   <= byte_idx_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_acc) begin
      out_valid_q <= 1'b1;
    end else if (evt_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, loaded with each accepted byte.
  always_ff @(posedge clk_i) begin
    if (rx_acc) begin
      ev_q   <= ev_d;
      data_q <= d;
      pos_q  <= pos_d;
      cmd_q  <= cmd_d;
    end
  end

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> rx_i.ready)
    else $error("input stalled while the output register is empty");

  // While the rest of a packet is received, at least the CRC byte is still due.
  a_rest_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REST) |-> (bytes_left_q != 8'd0))
    else $error("receiving packet body with no bytes left");

  // The CRC byte of a packet returns the parser to hunting.
  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && phase_q == PH_REST && bytes_left_q <= 8'd1) |=> (phase_q == PH_HUNT))
    else $error("parser did not return to hunting after the CRC byte");

  // A packet verdict is only given while the rest of a packet is received.
  a_verdict_in_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && (ev_d == EV_GOOD || ev_d == EV_CRC_BAD)) |-> (phase_q == PH_REST))
    else $error("packet verdict outside the packet body");

endmodule
